/* hw/rtl/incircle_predicate_2d_macros.svh */
// Assertion macros used by the in-circle predicate checker.
`ifndef INCIRCLE_PREDICATE_2D_MACROS_SVH
`define INCIRCLE_PREDICATE_2D_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define INCP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define INCP_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/incp_pkg.sv */
// Shared constants and width helpers for the in-circle predicate.
`timescale 1ns / 1ps
package incp_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int TOL_BITS       = 40;
  // Accepting edge to the edge that takes the result.
  localparam int PIPE_LAT       = 9;

  // Difference of two coordinates.
  function automatic int diff_bits(input int c);
    return c + 1;
  endfunction

  // Lifted squared norm, unsigned.
  function automatic int z_bits(input int c);
    return 2 * c + 2;
  endfunction

  // 2x2 minor, signed.
  function automatic int cross_bits(input int c);
    return 2 * c + 3;
  endfunction

  // Full determinant, signed.
  function automatic int det_bits(input int c);
    return 4 * c + 8;
  endfunction

endpackage

/* hw/rtl/incircle_predicate_2d.sv */
// Throughput: one item per cycle while busy is low, set by the nine-stage datapath (lift, wide
// product, sum and compare), each stage one register deep.
// busy is high only in the cycle after a reset cycle; the receiver cannot stall,
// so done shows for exactly one cycle per item and inside_res is high only alongside it.
// Reset clears the pipeline valid bits and sets tolerance to zero.
`timescale 1ns / 1ps
module incircle_predicate_2d #(
  parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  corner_a_x,
  input  logic signed [COORD_BITS-1:0]  corner_a_y,
  input  logic signed [COORD_BITS-1:0]  corner_b_x,
  input  logic signed [COORD_BITS-1:0]  corner_b_y,
  input  logic signed [COORD_BITS-1:0]  corner_c_x,
  input  logic signed [COORD_BITS-1:0]  corner_c_y,
  input  logic signed [COORD_BITS-1:0]  query_x,
  input  logic signed [COORD_BITS-1:0]  query_y,
  input  logic                          tolerance_we,
  input  logic [incp_pkg::TOL_BITS-1:0] tolerance,
  output logic                          done,
  output logic                          inside_res
);
  import incp_pkg::*;

  localparam int ZW = z_bits(COORD_BITS);
  localparam int XW = cross_bits(COORD_BITS);
  localparam int DW = det_bits(COORD_BITS);

  logic                         accept;
  logic [TOL_BITS-1:0]          tol;
  logic signed [COORD_BITS-1:0] pt_x [4];
  logic signed [COORD_BITS-1:0] pt_y [4];
  logic                         lift_valid;
  logic [ZW-1:0]                z [3];
  logic signed [XW-1:0]         minor [3];
  logic [2:0]                   mul_valid;
  logic signed [DW-1:0]         term [3];

  // A transfer happens on start while busy is low. busy only covers the
  // cycle right after reset, so the pipeline takes a new item every cycle while busy is low.
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Tolerance register; the user must write it only while the pipeline is empty, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (tolerance_we) begin
      tol <= tolerance;
    end
  end

  // Corners A, B, C in rows 0..2, the query point in row 3.
  assign pt_x[0] = corner_a_x;
  assign pt_x[1] = corner_b_x;
  assign pt_x[2] = corner_c_x;
  assign pt_x[3] = query_x;
  assign pt_y[0] = corner_a_y;
  assign pt_y[1] = corner_b_y;
  assign pt_y[2] = corner_c_y;
  assign pt_y[3] = query_y;

  // Stages 1-3: relative coordinates, products, lifted norms and minors.
  incp_lift #(
    .COORD_BITS(COORD_BITS)
  ) u_lift (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .out_valid(lift_valid),
    .z        (z),
    .minor    (minor)
  );

  // Stages 4-6: one wide product per row of the expansion along the
  // lifted column.
  for (genvar i = 0; i < 3; i++) begin : g_mul
    incp_wmul #(
      .COORD_BITS(COORD_BITS)
    ) u_wmul (
      .clk      (clk),
      .rst      (rst),
      .in_valid (lift_valid),
      .z        (z[i]),
      .minor    (minor[i]),
      .out_valid(mul_valid[i]),
      .term     (term[i])
    );
  end

  // Stages 7-9: add the three terms, compare strictly above tolerance.
  // All three rows advance in lockstep, so their valid bits agree.
  incp_decide #(
    .COORD_BITS(COORD_BITS)
  ) u_decide (
    .clk     (clk),
    .rst     (rst),
    .in_valid(mul_valid[0] && mul_valid[1] && mul_valid[2]),
    .term    (term),
    .tol     (tol),
    .done    (done),
    .hit     (inside_res)
  );

endmodule

/* hw/rtl/incp_lift.sv */
// Front end: differences to the query point, squares, minors and lifted norms.
`timescale 1ns / 1ps
module incp_lift #(
  parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  input  logic signed [COORD_BITS-1:0]                    pt_x [4],
  input  logic signed [COORD_BITS-1:0]                    pt_y [4],
  output logic                                            out_valid,
  output logic [incp_pkg::z_bits(COORD_BITS)-1:0]         z [3],
  output logic signed [incp_pkg::cross_bits(COORD_BITS)-1:0] minor [3]
);
  import incp_pkg::*;

  localparam int DFW = diff_bits(COORD_BITS);
  localparam int PW  = 2 * DFW;
  localparam int ZW  = z_bits(COORD_BITS);
  localparam int XW  = cross_bits(COORD_BITS);

  logic              v1;
  logic              v2;
  logic signed [DFW-1:0] ux [3];
  logic signed [DFW-1:0] uy [3];
  logic signed [PW-1:0]  sq_x [3];
  logic signed [PW-1:0]  sq_y [3];
  logic signed [PW-1:0]  pa [3];
  logic signed [PW-1:0]  pb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      // move each corner relative to the query point
      ux[i]    <= DFW'(pt_x[i]) - DFW'(pt_x[3]);
      uy[i]    <= DFW'(pt_y[i]) - DFW'(pt_y[3]);
      sq_x[i]  <= ux[i] * ux[i];
      sq_y[i]  <= uy[i] * uy[i];
      pa[i]    <= ux[J] * uy[K];
      pb[i]    <= uy[J] * ux[K];
      z[i]     <= ZW'($unsigned(sq_x[i])) + ZW'($unsigned(sq_y[i]));
      minor[i] <= XW'(pa[i]) - XW'(pb[i]);
    end
  end

endmodule

/* hw/rtl/incp_wmul.sv */
// Wide signed product of a lifted norm and a minor, split into four partials.
`timescale 1ns / 1ps
module incp_wmul #(
  parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               in_valid,
  input  logic [incp_pkg::z_bits(COORD_BITS)-1:0]            z,
  input  logic signed [incp_pkg::cross_bits(COORD_BITS)-1:0] minor,
  output logic                                               out_valid,
  output logic signed [incp_pkg::det_bits(COORD_BITS)-1:0]   term
);
  import incp_pkg::*;

  localparam int ZW   = z_bits(COORD_BITS);
  localparam int XW   = cross_bits(COORD_BITS);
  localparam int DW   = det_bits(COORD_BITS);
  localparam int H    = ZW / 2;
  localparam int ZHW  = ZW - H;
  localparam int CHW  = XW - H;
  localparam int MW   = ZHW + 1 + CHW;
  localparam int CATW = MW + 2 * H;

  logic                   v4;
  logic                   v5;
  logic [H-1:0]           zl;
  logic [ZHW-1:0]         zh;
  logic [H-1:0]           cl;
  logic signed [CHW-1:0]  ch;
  logic [2*H-1:0]         p_ll;
  logic [ZHW+H-1:0]       p_hl;
  logic signed [MW-1:0]   p_lh;
  logic signed [MW-1:0]   p_hh;
  logic signed [MW:0]     mid;
  logic signed [CATW-1:0] cat;

  assign zl = z[H-1:0];
  assign zh = z[ZW-1:H];
  assign cl = minor[H-1:0];
  assign ch = minor[XW-1:H];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4        <= in_valid;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    p_ll <= zl * cl;
    p_hl <= zh * cl;
    p_lh <= $signed({1'b0, zl}) * ch;
    p_hh <= $signed({1'b0, zh}) * ch;
    // high and low partials do not overlap: join them, add the middle ones
    cat  <= $signed({p_hh, p_ll});
    mid  <= (MW + 1)'(p_lh) + (MW + 1)'($signed({1'b0, p_hl}));
    term <= DW'(cat) + (DW'(mid) <<< H);
  end

endmodule

/* hw/rtl/incp_decide.sv */
// Sum of the three expansion terms and the tolerance compare.
`timescale 1ns / 1ps
module incp_decide #(
  parameter int COORD_BITS = incp_pkg::COORD_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  input  logic signed [incp_pkg::det_bits(COORD_BITS)-1:0] term [3],
  input  logic [incp_pkg::TOL_BITS-1:0]                    tol,
  output logic                                             done,
  output logic                                             hit
);
  import incp_pkg::*;

  localparam int DW = det_bits(COORD_BITS);
  localparam int CW = DW + TOL_BITS;

  logic                 v7;
  logic                 v8;
  logic signed [DW-1:0] t01;
  logic signed [DW-1:0] t2;
  logic signed [DW-1:0] det;
  logic                 above;

  assign above = !det[DW-1] && (CW'($unsigned(det)) > CW'(tol));

  always_ff @(posedge clk) begin
    t01 <= term[0] + term[1];
    t2  <= term[2];
    det <= t01 + t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7   <= 1'b0;
      v8   <= 1'b0;
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      v7   <= in_valid;
      v8   <= v7;
      done <= v8;
      hit  <= v8 && above;
    end
  end

endmodule

/* hw/rtl/incp_checker.sv */
// Port-level checker for the in-circle predicate, bound to the top level.
`timescale 1ns / 1ps
`include "incircle_predicate_2d_macros.svh"
module incp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic inside_res
);
  import incp_pkg::*;

  `INCP_ASSERT_NEXT(a_busy_free, clk, !rst, !busy, "busy high outside reset recovery")
  `INCP_ASSERT_NEXT(a_quiet_reset, clk, rst, !done && !inside_res, "result after reset")
  `INCP_ASSERT_IMPLY(a_done_lat, clk, rst, done, $past(start && !busy, PIPE_LAT), "stray result")
  `INCP_ASSERT_IMPLY(a_res_gated, clk, rst, !done, !inside_res, "inside without strobe")

endmodule

bind incircle_predicate_2d incp_checker u_incp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .inside_res(inside_res)
);
